[sv/imusbc_pkg.sv]
// imusbc_pkg: shared widths, codes, item and command types of the imu still-bias calibrator
// no dependencies; every other file of the block refers to it by scoped names
`timescale 1ns / 1ps

package imusbc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 28;
    localparam int CNT_W      = 12;
    localparam int THR_W      = 15;
    localparam int GRAV_W     = 14;
    localparam int NUM_GYRO   = 3;
    localparam int NUM_AXES   = 6;
    localparam int AXIS_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int STEP_W     = 5;
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQ_STEPS   = 4;
    localparam int ROOT_W     = 14;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int MUL_W      = SAMPLE_W + 1;
    localparam int SQ_W       = 31;
    localparam int REM_W      = 33;

    localparam logic [THR_W-1:0]  THR_RESET     = 15'd48;
    localparam logic [CNT_W-1:0]  SAMPLES_RESET = 12'd400;
    localparam logic [GRAV_W-1:0] GRAV_RESET    = 14'd8192;

    localparam logic ACTION_RESTART = 1'b1;

    // axis order of the running sums and of the bias results
    localparam logic [AXIS_W-1:0] AX_ACCEL_X = 3'd3;
    localparam logic [AXIS_W-1:0] AX_ACCEL_Y = 3'd4;
    localparam logic [AXIS_W-1:0] AX_ACCEL_Z = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STILL_THRESHOLD = 2'd0,
        CFG_STILL_SAMPLES   = 2'd1,
        CFG_GRAVITY_ONE     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SQ_GRAVITY = 2'd0,
        SQ_ACCEL_X = 2'd1,
        SQ_ACCEL_Y = 2'd2
    } t_sq_sel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_SUB  = 2'd2
    } t_acc_op;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gyro_bias_x;
        logic signed [SAMPLE_W-1:0] gyro_bias_y;
        logic signed [SAMPLE_W-1:0] gyro_bias_z;
        logic signed [SAMPLE_W-1:0] accel_bias_x;
        logic signed [SAMPLE_W-1:0] accel_bias_y;
        logic signed [SAMPLE_W-1:0] accel_bias_z;
    } t_bias;

    typedef struct packed {
        logic              capture;
        logic              update;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic [AXIS_W-1:0] axis;
        logic              mul_en;
        t_sq_sel           mul_sel;
        t_acc_op           acc_op;
        logic              root_load;
        logic              root_step;
        logic              finish;
    } t_dp_cmd;

    typedef struct packed {
        logic complete;
    } t_dp_status;

endpackage

[sv/imusbc_if.sv]
// imusbc_if: valid/ready channels carrying sample items in and bias items out
// depends on imusbc_pkg for the payload types
`timescale 1ns / 1ps

interface imusbc_sample_if;
    logic                 valid;
    logic                 ready;
    imusbc_pkg::t_sample  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imusbc_bias_if;
    logic               valid;
    logic               ready;
    imusbc_pkg::t_bias  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/imusbc_dp.sv]
// imusbc_dp: datapath of the still-bias calibrator (config registers, run sums,
// shared restoring divider, squarer, digit-by-digit root, result register); uses imusbc_pkg
`timescale 1ns / 1ps

module imusbc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [imusbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imusbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  imusbc_pkg::t_sample                 i_sample,
    input  imusbc_pkg::t_dp_cmd                 i_cmd,
    output imusbc_pkg::t_dp_status              o_status,
    output imusbc_pkg::t_bias                   o_bias
);

    localparam int SW  = imusbc_pkg::SAMPLE_W;
    localparam int SUW = imusbc_pkg::SUM_W;
    localparam int CW  = imusbc_pkg::CNT_W;
    localparam int RW  = imusbc_pkg::ROOT_W;

    // configuration
    logic [imusbc_pkg::THR_W-1:0]  r_thr;
    logic [CW-1:0]                 r_samples;
    logic [imusbc_pkg::GRAV_W-1:0] r_grav;

    // run state
    imusbc_pkg::t_sample  r_item;
    logic signed [SW-1:0] r_prev [imusbc_pkg::NUM_GYRO];
    logic signed [SUW-1:0] r_sum [imusbc_pkg::NUM_AXES];
    logic [CW-1:0]        r_count;

    // divider
    logic [SUW-1:0] r_dnum;
    logic [CW-1:0]  r_drem;
    logic           r_dneg;
    logic signed [SW-1:0] r_bias [imusbc_pkg::NUM_AXES];

    // gravity remainder and root
    logic [imusbc_pkg::SQ_W-1:0]          r_prod;
    logic signed [imusbc_pkg::REM_W-1:0]  r_rem;
    logic [imusbc_pkg::RAD_W-1:0]         r_rad;
    logic [imusbc_pkg::SREM_W-1:0]        r_srem;
    logic [RW-1:0]                        r_root;

    imusbc_pkg::t_bias r_out;

    logic signed [SW-1:0]  w_gyro [imusbc_pkg::NUM_GYRO];
    logic signed [SW-1:0]  w_axis [imusbc_pkg::NUM_AXES];
    logic signed [SW:0]    w_diff [imusbc_pkg::NUM_GYRO];
    logic [SW:0]           w_mag  [imusbc_pkg::NUM_GYRO];
    logic                  w_still;
    logic [CW:0]           w_count_inc;
    logic [CW-1:0]         w_need;
    logic signed [SUW-1:0] w_sel_sum;
    logic [CW:0]           w_dtrial;
    logic                  w_qbit;
    logic [SW-1:0]         w_quot;
    logic signed [imusbc_pkg::MUL_W-1:0]   w_mop;
    logic signed [2*imusbc_pkg::MUL_W-1:0] w_prod;
    logic [imusbc_pkg::SREM_W+1:0] w_rt;
    logic [imusbc_pkg::SREM_W+1:0] w_trial;
    logic signed [SW+1:0]  w_z;
    logic signed [SW-1:0]  w_zsat;

    // still test of the held sample against the previous gyro reading
    always_comb begin
        w_gyro[0] = r_item.gyro_x;
        w_gyro[1] = r_item.gyro_y;
        w_gyro[2] = r_item.gyro_z;
        w_axis[0] = r_item.gyro_x;
        w_axis[1] = r_item.gyro_y;
        w_axis[2] = r_item.gyro_z;
        w_axis[3] = r_item.accel_x;
        w_axis[4] = r_item.accel_y;
        w_axis[5] = r_item.accel_z;
        w_still = 1'b1;
        for (int i = 0; i < imusbc_pkg::NUM_GYRO; i++) begin
            w_diff[i] = {w_gyro[i][SW-1], w_gyro[i]} - {r_prev[i][SW-1], r_prev[i]};
            w_mag[i]  = w_diff[i][SW] ? (SW+1)'(-w_diff[i]) : w_diff[i];
            if (w_mag[i] > {2'b00, r_thr}) begin
                w_still = 1'b0;
            end
        end
        w_count_inc = {1'b0, r_count} + 1'b1;
        w_need      = (r_samples == '0) ? CW'(1) : r_samples;
    end

    assign o_status.complete = w_still && (w_count_inc >= {1'b0, w_need});

    // divider step: one quotient bit of |sum| / count
    always_comb begin
        w_sel_sum = r_sum[i_cmd.axis];
        w_dtrial  = {r_drem, r_dnum[SUW-1]};
        w_qbit    = (w_dtrial >= {1'b0, r_count});
        w_quot    = r_dnum[SW-1:0];
    end

    // squarer operand
    always_comb begin
        case (i_cmd.mul_sel)
            imusbc_pkg::SQ_GRAVITY: w_mop = {3'b000, r_grav};
            imusbc_pkg::SQ_ACCEL_X: w_mop = {r_bias[imusbc_pkg::AX_ACCEL_X][SW-1],
                                             r_bias[imusbc_pkg::AX_ACCEL_X]};
            imusbc_pkg::SQ_ACCEL_Y: w_mop = {r_bias[imusbc_pkg::AX_ACCEL_Y][SW-1],
                                             r_bias[imusbc_pkg::AX_ACCEL_Y]};
            default:                w_mop = '0;
        endcase
        w_prod = w_mop * w_mop;
    end

    // root step and final z saturation
    always_comb begin
        w_rt    = {r_srem, r_rad[imusbc_pkg::RAD_W-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_z     = {{2{r_bias[imusbc_pkg::AX_ACCEL_Z][SW-1]}}, r_bias[imusbc_pkg::AX_ACCEL_Z]}
                - $signed({4'b0000, r_root});
        if (w_z < -18'sd32768) begin
            w_zsat = 16'sh8000;
        end else if (w_z > 18'sd32767) begin
            w_zsat = 16'sh7fff;
        end else begin
            w_zsat = w_z[SW-1:0];
        end
    end

    // control-bearing state: configuration, previous gyro, sums and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= imusbc_pkg::THR_RESET;
            r_samples <= imusbc_pkg::SAMPLES_RESET;
            r_grav    <= imusbc_pkg::GRAV_RESET;
            r_count   <= '0;
            for (int i = 0; i < imusbc_pkg::NUM_GYRO; i++) begin
                r_prev[i] <= '0;
            end
            for (int i = 0; i < imusbc_pkg::NUM_AXES; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    imusbc_pkg::CFG_STILL_THRESHOLD: r_thr <= i_cfg_data[imusbc_pkg::THR_W-1:0];
                    imusbc_pkg::CFG_STILL_SAMPLES:   r_samples <= i_cfg_data[CW-1:0];
                    imusbc_pkg::CFG_GRAVITY_ONE:     r_grav <= i_cfg_data[imusbc_pkg::GRAV_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                for (int i = 0; i < imusbc_pkg::NUM_GYRO; i++) begin
                    r_prev[i] <= w_gyro[i];
                end
                if (w_still) begin
                    for (int i = 0; i < imusbc_pkg::NUM_AXES; i++) begin
                        r_sum[i] <= r_sum[i] + {{(SUW-SW){w_axis[i][SW-1]}}, w_axis[i]};
                    end
                    r_count <= w_count_inc[CW-1:0];
                end else begin
                    for (int i = 0; i < imusbc_pkg::NUM_AXES; i++) begin
                        r_sum[i] <= '0;
                    end
                    r_count <= '0;
                end
            end
            if (i_cmd.finish) begin
                for (int i = 0; i < imusbc_pkg::NUM_AXES; i++) begin
                    r_sum[i] <= '0;
                end
                r_count <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_sample;
        end
        if (i_cmd.div_load) begin
            r_dneg <= w_sel_sum[SUW-1];
            r_dnum <= w_sel_sum[SUW-1] ? SUW'(-w_sel_sum) : w_sel_sum;
            r_drem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dnum <= {r_dnum[SUW-2:0], w_qbit};
            r_drem <= w_qbit ? CW'(w_dtrial - {1'b0, r_count}) : w_dtrial[CW-1:0];
        end
        if (i_cmd.div_store) begin
            r_bias[i_cmd.axis] <= r_dneg ? SW'(-w_quot) : w_quot;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod[imusbc_pkg::SQ_W-1:0];
        end
        case (i_cmd.acc_op)
            imusbc_pkg::ACC_LOAD: r_rem <= $signed({2'b00, r_prod});
            imusbc_pkg::ACC_SUB:  r_rem <= r_rem - $signed({2'b00, r_prod});
            default: ;
        endcase
        if (i_cmd.root_load) begin
            r_rad  <= (r_rem > 0) ? r_rem[imusbc_pkg::RAD_W-1:0] : '0;
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[imusbc_pkg::RAD_W-3:0], 2'b00};
            if (w_rt >= w_trial) begin
                r_srem <= imusbc_pkg::SREM_W'(w_rt - w_trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_srem <= w_rt[imusbc_pkg::SREM_W-1:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_out.gyro_bias_x  <= r_bias[0];
            r_out.gyro_bias_y  <= r_bias[1];
            r_out.gyro_bias_z  <= r_bias[2];
            r_out.accel_bias_x <= r_bias[imusbc_pkg::AX_ACCEL_X];
            r_out.accel_bias_y <= r_bias[imusbc_pkg::AX_ACCEL_Y];
            r_out.accel_bias_z <= w_zsat;
        end
    end

    assign o_bias = r_out;

endmodule

[sv/imusbc_ctrl.sv]
// imusbc_ctrl: sequencer of the still-bias calibrator, drives the datapath commands
// and owns the calibrated flag and the result valid; uses imusbc_pkg
`timescale 1ns / 1ps

module imusbc_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_action,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output imusbc_pkg::t_dp_cmd     o_cmd,
    input  imusbc_pkg::t_dp_status  i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_STORE,
        S_SQUARE,
        S_ROOT_LOAD,
        S_ROOT_RUN,
        S_FINISH
    } t_state;

    localparam int SW = imusbc_pkg::STEP_W;

    t_state                          r_state;
    logic                            r_calibrated;
    logic                            r_out_valid;
    logic [SW-1:0]                   r_cnt;
    logic [imusbc_pkg::AXIS_W-1:0]   r_axis;
    logic                            w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.axis      = r_axis;
        o_cmd.mul_sel   = imusbc_pkg::SQ_GRAVITY;
        o_cmd.acc_op    = imusbc_pkg::ACC_HOLD;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid
                       && (i_in_action != imusbc_pkg::ACTION_RESTART) && !r_calibrated;
        o_cmd.update    = (r_state == S_STEP);
        o_cmd.div_load  = (r_state == S_DIV_LOAD);
        o_cmd.div_step  = (r_state == S_DIV_RUN);
        o_cmd.div_store = (r_state == S_DIV_STORE);
        o_cmd.root_load = (r_state == S_ROOT_LOAD);
        o_cmd.root_step = (r_state == S_ROOT_RUN);
        o_cmd.finish    = (r_state == S_FINISH) && w_out_free;
        // square g, then x and y biases, accumulating one step behind
        if (r_state == S_SQUARE) begin
            case (r_cnt[1:0])
                2'd0: begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = imusbc_pkg::SQ_GRAVITY;
                end
                2'd1: begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = imusbc_pkg::SQ_ACCEL_X;
                    o_cmd.acc_op  = imusbc_pkg::ACC_LOAD;
                end
                2'd2: begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = imusbc_pkg::SQ_ACCEL_Y;
                    o_cmd.acc_op  = imusbc_pkg::ACC_SUB;
                end
                default: begin
                    o_cmd.acc_op  = imusbc_pkg::ACC_SUB;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_calibrated <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_axis       <= '0;
        end else begin
            // a new bias item replaces a taken one in the same cycle
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_action == imusbc_pkg::ACTION_RESTART) begin
                            r_calibrated <= 1'b0;
                        end else if (!r_calibrated) begin
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_axis  <= '0;
                    r_state <= i_status.complete ? S_DIV_LOAD : S_IDLE;
                end
                S_DIV_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    if (r_cnt == SW'(imusbc_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_DIV_STORE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV_STORE: begin
                    if (r_axis == imusbc_pkg::AXIS_W'(imusbc_pkg::NUM_AXES - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_SQUARE;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_DIV_LOAD;
                    end
                end
                S_SQUARE: begin
                    if (r_cnt == SW'(imusbc_pkg::SQ_STEPS - 1)) begin
                        r_state <= S_ROOT_LOAD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ROOT_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_ROOT_RUN;
                end
                S_ROOT_RUN: begin
                    if (r_cnt == SW'(imusbc_pkg::ROOT_STEPS - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_calibrated <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/imu_still_bias_calibrator.sv]
// imu_still_bias_calibrator: top level, joins the sequencer and the datapath to the channels
// depends on imusbc_pkg, imusbc_if, imusbc_ctrl and imusbc_dp
`timescale 1ns / 1ps

// zero-bias calibration for a six-axis imu. each sample item carries gyro x/y/z in
// 1/16 deg/s and accel x/y/z in units where gravity_one is one g. a sample is still when
// every gyro axis moved by at most still_threshold from the previous sample (the first
// sample compares against zero); still samples are summed per axis and counted, any larger
// jump clears the run. when the run reaches still_samples (zero acts as one) one bias item
// goes out: the six averages truncated toward zero, with accel z replaced by the z average
// minus floor(sqrt(g^2 - ax^2 - ay^2)) (zero when that is not positive), saturated to 16
// bits. the block then drops samples until a restart item (action = 1) arrives; a restart
// only re-arms and keeps the previous gyro reading; the sums and the count are cleared
// when the bias item is loaded. timing: an ordinary sample is captured when accepted and
// folded into the sums in the next cycle, and no new sample is taken before that; restart
// and dropped items leave the input open. the completing sample keeps the input closed for
// the sum update, for each of the 6 axes the shared restoring divider (load, 28 quotient
// bits, store), the squaring steps, the digit-by-digit root (load plus 14 result bits) and
// the load of the output register; longer if an earlier bias item is still waiting on the
// output. the bias item sits in an output register, so new samples are accepted while it
// waits. configuration (index 0 still_threshold, 1 still_samples, 2 gravity_one) should be
// written only while the block is idle.

module imu_still_bias_calibrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    imusbc_sample_if.sink                       i_sample,
    imusbc_bias_if.source                       o_bias,
    input  logic                                i_cfg_we,
    input  logic [imusbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imusbc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // command and status bundles between the sequencer and the datapath
    imusbc_pkg::t_dp_cmd     w_cmd;
    imusbc_pkg::t_dp_status  w_status;
    imusbc_pkg::t_bias       w_bias;
    logic                    w_in_ready;
    logic                    w_out_valid;

    // sequencer: item handshakes, calibrated flag, step counting
    imusbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .i_in_action (i_sample.data.action),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_bias.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // datapath: config, run sums, divider, squarer, root, bias register
    imusbc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample.data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_bias     (w_bias)
    );

    // channel hookup
    assign i_sample.ready = w_in_ready;
    assign o_bias.valid   = w_out_valid;
    assign o_bias.data    = w_bias;

endmodule
